### hdl/gdr_pkg.sv
// Shared types, constants and control codes of the grid DDA column ray caster.
package gdr_pkg;

	localparam int MAP_COLS_DEF    = 32;
	localparam int MAP_ROWS_DEF    = 32;
	localparam int SCREEN_COLS_DEF = 1920;
	localparam int SCREEN_ROWS_DEF = 1080;

	localparam int DIST_W    = 48;
	localparam int DELTA_W   = 41;
	localparam int NUM_W     = 31;
	localparam int RD_W      = 27;
	localparam int CAM_W     = 24;
	localparam int COORD_W   = 8;
	localparam int DELTA_MAX_LOG = 40;

	localparam logic [2:0] REG_EYE_X  = 3'd0;
	localparam logic [2:0] REG_EYE_Y  = 3'd1;
	localparam logic [2:0] REG_LOOK_X = 3'd2;
	localparam logic [2:0] REG_LOOK_Y = 3'd3;
	localparam logic [2:0] REG_LENS_X = 3'd4;
	localparam logic [2:0] REG_LENS_Y = 3'd5;

	localparam logic       CMD_CAST    = 1'b0;
	localparam logic       CMD_WRITE   = 1'b1;
	localparam logic [1:0] TILE_EMPTY  = 2'd0;
	localparam logic [1:0] TILE_WALL   = 2'd1;
	localparam logic [1:0] TILE_BORDER = 2'd2;

	typedef struct packed {
		logic        command;
		logic [10:0] column;
		logic [4:0]  tile_col;
		logic [4:0]  tile_row;
		logic [1:0]  tile_code;
	} req_item_t;

	typedef struct packed {
		logic [10:0] column_out;
		logic        hit_side;
		logic        hit_kind;
		logic [10:0] span_top;
		logic [10:0] span_bottom;
	} rsp_item_t;

	typedef struct packed {
		logic [15:0] eye_x;
		logic [15:0] eye_y;
		logic [15:0] look_x;
		logic [15:0] look_y;
		logic [15:0] lens_x;
		logic [15:0] lens_y;
	} cfg_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CAM_GO, S_CAM_WAIT, S_RAY_MUL, S_RAY_SUM,
		S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_SIDE_MUL, S_SIDE_SUM,
		S_STEP, S_FETCH, S_CHECK, S_DIST, S_H_GO, S_H_WAIT, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_ACCEPT, OP_DIV_CAM, OP_CAM_TAKE, OP_RAY_MUL,
		OP_RAY_SUM, OP_DIV_DX, OP_DX_TAKE, OP_DIV_DY, OP_DY_TAKE, OP_SIDE_MUL,
		OP_SIDE_SUM, OP_STEP, OP_EDGE, OP_CHECK, OP_DIST, OP_DIV_H, OP_H_TAKE,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic is_write;
		logic div_busy;
		logic clear_last;
		logic rdx_zero;
		logic rdy_zero;
		logic oog;
		logic tile_hit;
		logic perp_zero;
		logic out_busy;
	} dp_stat_t;

endpackage

### hdl/gdr_chan_if.sv
// Valid/ready channel interface that carries one payload per transaction.
interface gdr_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### hdl/gdr_div.sv
// Restoring divider that produces one quotient bit per cycle.
module gdr_div import gdr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DIST_W-1:0] den,
	output logic              busy,
	output logic [NUM_W-1:0]  quo
);

	logic              busy_q;
	logic [4:0]        cnt_q;
	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DIST_W:0]   trial;
	logic              fits;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(NUM_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DIST_W'(trial - {1'b0, den_q}) : trial[DIST_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

### hdl/gdr_dp.sv
// Datapath of the ray caster: tile map, ray setup, DDA walk and wall span.
module gdr_dp import gdr_pkg::*; #(
	parameter int MAP_COLS    = MAP_COLS_DEF,
	parameter int MAP_ROWS    = MAP_ROWS_DEF,
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_op_t    op,
	input  cfg_t      cfg,
	input  req_item_t req_item,
	input  logic      rsp_ready,
	output logic      rsp_valid,
	output rsp_item_t rsp_item,
	output dp_stat_t  stat
);

	localparam int CW = $clog2(MAP_COLS);
	localparam int RW = $clog2(MAP_ROWS);
	localparam int AW = CW + RW;
	localparam int DEPTH = 1 << AW;
	localparam int HCAP = 4 * SCREEN_ROWS;
	localparam int H_W = $clog2(HCAP + 1);
	localparam int HALF_ROWS = SCREEN_ROWS / 2;
	localparam logic signed [COORD_W-1:0] COLS_S = COORD_W'(MAP_COLS);
	localparam logic signed [COORD_W-1:0] ROWS_S = COORD_W'(MAP_ROWS);
	// The camera offset divides by the screen width through a reciprocal
	// multiplication that is exact for every 11-bit column.
	localparam int     CAM_SH  = 26 + $clog2(SCREEN_COLS);
	localparam longint CAM_M   = ((longint'(1) << CAM_SH) + longint'(SCREEN_COLS) - 1) /
		longint'(SCREEN_COLS);
	localparam int     CAM_M_W = $clog2(CAM_M + 1);
	localparam int     CAM_P_W = 11 + CAM_M_W;

	logic [1:0]                 tile_mem [DEPTH];
	logic [1:0]                 tile_rd_q;
	logic [AW-1:0]              clr_q;
	logic [RW-1:0]              clr_row;
	logic [CW-1:0]              clr_col;
	logic [1:0]                 clr_code;
	logic                       wr_in_map;

	logic [10:0]                col_q;
	logic [CAM_P_W-1:0]         camp_s1;
	logic signed [CAM_W-1:0]    cam_q;
	logic signed [CAM_W+15:0]   prodx_s1, prody_s1;
	logic signed [RD_W-1:0]     rdx_q, rdy_q;
	logic [RD_W-1:0]            rdx_abs, rdy_abs;
	logic [DIST_W-1:0]          dx_q, dy_q, sdx_q, sdy_q, perp_q;
	logic [11:0]                fx, fy;
	logic [DELTA_W+11:0]        sidex_s1, sidey_s1;
	logic signed [COORD_W-1:0]  mx_q, my_q;
	logic                       side_q, kind_q;
	logic [H_W-1:0]             height_q;

	logic                       div_start, div_busy;
	logic [NUM_W-1:0]           div_num, div_quo;
	logic [DIST_W-1:0]          div_den;

	logic                       rsp_valid_q;
	rsp_item_t                  rsp_q;
	logic [10:0]                top_w, bot_w;

	assign clr_row   = clr_q[AW-1:CW];
	assign clr_col   = clr_q[CW-1:0];
	assign clr_code  = (clr_row == '0 || clr_row == RW'(MAP_ROWS - 1) ||
		clr_col == '0 || clr_col == CW'(MAP_COLS - 1)) ? TILE_BORDER : TILE_EMPTY;
	assign wr_in_map = (32'(req_item.tile_col) < MAP_COLS) &&
		(32'(req_item.tile_row) < MAP_ROWS);

	always_ff @(posedge clk) begin
		if (op == OP_CLEAR) begin
			tile_mem[clr_q] <= clr_code;
		end else if (op == OP_ACCEPT && req_item.command == CMD_WRITE && wr_in_map) begin
			tile_mem[{RW'(req_item.tile_row), CW'(req_item.tile_col)}] <= req_item.tile_code;
		end
		tile_rd_q <= tile_mem[{my_q[RW-1:0], mx_q[CW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (op == OP_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign rdx_abs = rdx_q[RD_W-1] ? RD_W'(-rdx_q) : RD_W'(rdx_q);
	assign rdy_abs = rdy_q[RD_W-1] ? RD_W'(-rdy_q) : RD_W'(rdy_q);

	always_comb begin
		div_start = 1'b0;
		div_num   = NUM_W'(1) << 30;
		div_den   = DIST_W'(rdx_abs);
		case (op)
			OP_DIV_DX: begin
				div_start = rdx_q != '0;
			end
			OP_DIV_DY: begin
				div_start = rdy_q != '0;
				div_den   = DIST_W'(rdy_abs);
			end
			OP_DIV_H: begin
				div_start = perp_q != '0;
				div_num   = NUM_W'(SCREEN_ROWS) << 16;
				div_den   = perp_q;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	gdr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign fx = rdx_q[RD_W-1] ? {1'b0, cfg.eye_x[10:0]} : 12'd2048 - {1'b0, cfg.eye_x[10:0]};
	assign fy = rdy_q[RD_W-1] ? {1'b0, cfg.eye_y[10:0]} : 12'd2048 - {1'b0, cfg.eye_y[10:0]};

	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				col_q <= req_item.column;
			end
			OP_DIV_CAM: begin
				camp_s1 <= col_q * CAM_M_W'(CAM_M);
			end
			OP_CAM_TAKE: begin
				cam_q <= $signed(CAM_W'(camp_s1 >> (CAM_SH - 15))) - CAM_W'(16384);
			end
			OP_RAY_MUL: begin
				prodx_s1 <= $signed(cfg.lens_x) * cam_q;
				prody_s1 <= $signed(cfg.lens_y) * cam_q;
			end
			OP_RAY_SUM: begin
				rdx_q <= RD_W'($signed(cfg.look_x)) + RD_W'(prodx_s1 >>> 14);
				rdy_q <= RD_W'($signed(cfg.look_y)) + RD_W'(prody_s1 >>> 14);
				mx_q  <= COORD_W'(cfg.eye_x[15:11]);
				my_q  <= COORD_W'(cfg.eye_y[15:11]);
			end
			OP_DIV_DX: begin
				dx_q <= DIST_W'(1) << DELTA_MAX_LOG;
			end
			OP_DX_TAKE: begin
				dx_q <= DIST_W'(div_quo);
			end
			OP_DIV_DY: begin
				dy_q <= DIST_W'(1) << DELTA_MAX_LOG;
			end
			OP_DY_TAKE: begin
				dy_q <= DIST_W'(div_quo);
			end
			OP_SIDE_MUL: begin
				sidex_s1 <= fx * dx_q[DELTA_W-1:0];
				sidey_s1 <= fy * dy_q[DELTA_W-1:0];
			end
			OP_SIDE_SUM: begin
				sdx_q <= DIST_W'(sidex_s1 >> 11);
				sdy_q <= DIST_W'(sidey_s1 >> 11);
			end
			OP_STEP: begin
				if (sdx_q < sdy_q) begin
					mx_q   <= rdx_q[RD_W-1] ? mx_q - COORD_W'(1) : mx_q + COORD_W'(1);
					sdx_q  <= sdx_q + dx_q;
					side_q <= 1'b0;
				end else begin
					my_q   <= rdy_q[RD_W-1] ? my_q - COORD_W'(1) : my_q + COORD_W'(1);
					sdy_q  <= sdy_q + dy_q;
					side_q <= 1'b1;
				end
			end
			OP_EDGE: begin
				kind_q <= 1'b1;
			end
			OP_CHECK: begin
				kind_q <= tile_rd_q != TILE_WALL;
			end
			OP_DIST: begin
				perp_q <= side_q ? sdy_q - dy_q : sdx_q - dx_q;
			end
			OP_DIV_H: begin
				height_q <= H_W'(HCAP);
			end
			OP_H_TAKE: begin
				height_q <= (div_quo > NUM_W'(HCAP)) ? H_W'(HCAP) : H_W'(div_quo);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		int half_i;
		int top_i;
		int bot_i;
		half_i = int'(height_q >> 1);
		top_i  = (half_i > HALF_ROWS) ? 0 : HALF_ROWS - half_i;
		bot_i  = HALF_ROWS + half_i;
		if (bot_i > SCREEN_ROWS - 1) begin
			bot_i = SCREEN_ROWS - 1;
		end
		top_w = 11'(top_i);
		bot_w = 11'(bot_i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (op == OP_OUT) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_OUT) begin
			rsp_q.column_out  <= col_q;
			rsp_q.hit_side    <= side_q;
			rsp_q.hit_kind    <= kind_q;
			rsp_q.span_top    <= top_w;
			rsp_q.span_bottom <= bot_w;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	always_comb begin
		stat.is_write   = req_item.command == CMD_WRITE;
		stat.div_busy   = div_busy;
		stat.clear_last = &clr_q;
		stat.rdx_zero   = rdx_q == '0;
		stat.rdy_zero   = rdy_q == '0;
		stat.oog        = mx_q < 0 || mx_q >= COLS_S || my_q < 0 || my_q >= ROWS_S;
		stat.tile_hit   = tile_rd_q == TILE_WALL || tile_rd_q == TILE_BORDER;
		stat.perp_zero  = perp_q == '0;
		stat.out_busy   = rsp_valid_q && !rsp_ready;
	end

endmodule

### hdl/gdr_ctrl.sv
// Controller state machine that sequences the ray caster datapath.
module gdr_ctrl import gdr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_op_t   op
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR:    if (stat.clear_last) state_d = S_IDLE;
			S_IDLE:     if (in_valid && !stat.is_write) state_d = S_CAM_GO;
			S_CAM_GO:   state_d = S_CAM_WAIT;
			S_CAM_WAIT: if (!stat.div_busy) state_d = S_RAY_MUL;
			S_RAY_MUL:  state_d = S_RAY_SUM;
			S_RAY_SUM:  state_d = S_DX_GO;
			S_DX_GO:    state_d = stat.rdx_zero ? S_DY_GO : S_DX_WAIT;
			S_DX_WAIT:  if (!stat.div_busy) state_d = S_DY_GO;
			S_DY_GO:    state_d = stat.rdy_zero ? S_SIDE_MUL : S_DY_WAIT;
			S_DY_WAIT:  if (!stat.div_busy) state_d = S_SIDE_MUL;
			S_SIDE_MUL: state_d = S_SIDE_SUM;
			S_SIDE_SUM: state_d = S_STEP;
			S_STEP:     state_d = S_FETCH;
			S_FETCH:    state_d = stat.oog ? S_DIST : S_CHECK;
			S_CHECK:    state_d = stat.tile_hit ? S_DIST : S_STEP;
			S_DIST:     state_d = S_H_GO;
			S_H_GO:     state_d = stat.perp_zero ? S_DONE : S_H_WAIT;
			S_H_WAIT:   if (!stat.div_busy) state_d = S_DONE;
			S_DONE:     if (!stat.out_busy) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR:    op = OP_CLEAR;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) op = OP_ACCEPT;
			end
			S_CAM_GO:   op = OP_DIV_CAM;
			S_CAM_WAIT: if (!stat.div_busy) op = OP_CAM_TAKE;
			S_RAY_MUL:  op = OP_RAY_MUL;
			S_RAY_SUM:  op = OP_RAY_SUM;
			S_DX_GO:    op = OP_DIV_DX;
			S_DX_WAIT:  if (!stat.div_busy) op = OP_DX_TAKE;
			S_DY_GO:    op = OP_DIV_DY;
			S_DY_WAIT:  if (!stat.div_busy) op = OP_DY_TAKE;
			S_SIDE_MUL: op = OP_SIDE_MUL;
			S_SIDE_SUM: op = OP_SIDE_SUM;
			S_STEP:     op = OP_STEP;
			S_FETCH:    if (stat.oog) op = OP_EDGE;
			S_CHECK:    if (stat.tile_hit) op = OP_CHECK;
			S_DIST:     op = OP_DIST;
			S_H_GO:     op = OP_DIV_H;
			S_H_WAIT:   if (!stat.div_busy) op = OP_H_TAKE;
			S_DONE:     if (!stat.out_busy) op = OP_OUT;
			default:    op = OP_NONE;
		endcase
	end

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !stat.div_busy)
		else $error("divider still busy while the controller is idle");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_OUT |-> !stat.out_busy)
		else $error("result register loaded while a transaction is pending");

	a_check_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> !stat.oog)
		else $error("tile check reached with the walk outside the map");

endmodule

### hdl/gdr_cfg.sv
// APB register file holding the viewer position, view direction and camera plane.
module gdr_cfg import gdr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eye_x  <= 16'd20480;
			cfg_q.eye_y  <= 16'd20480;
			cfg_q.look_x <= 16'd16384;
			cfg_q.look_y <= 16'd0;
			cfg_q.lens_x <= 16'd0;
			cfg_q.lens_y <= 16'd10813;
		end else if (wr_en) begin
			case (idx)
				REG_EYE_X:  cfg_q.eye_x  <= pwdata[15:0];
				REG_EYE_Y:  cfg_q.eye_y  <= pwdata[15:0];
				REG_LOOK_X: cfg_q.look_x <= pwdata[15:0];
				REG_LOOK_Y: cfg_q.look_y <= pwdata[15:0];
				REG_LENS_X: cfg_q.lens_x <= pwdata[15:0];
				REG_LENS_Y: cfg_q.lens_y <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_EYE_X:  prdata = {16'd0, cfg_q.eye_x};
			REG_EYE_Y:  prdata = {16'd0, cfg_q.eye_y};
			REG_LOOK_X: prdata = {16'd0, cfg_q.look_x};
			REG_LOOK_Y: prdata = {16'd0, cfg_q.look_y};
			REG_LENS_X: prdata = {16'd0, cfg_q.lens_x};
			REG_LENS_Y: prdata = {16'd0, cfg_q.lens_y};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### hdl/grid_dda_column_raycaster.sv
// Top level of the grid DDA column ray caster.
// After reset the block fills the tile map, border tiles around the edge and empty tiles
// inside, and takes no transaction meanwhile. A tile write is taken in the idle state. A
// column cast sets up the ray, divides for the two step lengths, walks the grid cell by cell
// (step, fetch, check) until it hits a wall or leaves the map, and divides for the wall
// height; the three divisions share the one divider, which makes one quotient bit per cycle.
// A zero ray component or zero wall distance skips its division. A finished result sits in
// an output register, so the next transaction is accepted while it waits to be taken.
module grid_dda_column_raycaster import gdr_pkg::*; #(
	parameter int MAP_COLS    = MAP_COLS_DEF,
	parameter int MAP_ROWS    = MAP_ROWS_DEF,
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gdr_chan_if.sink    req,
	gdr_chan_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t      cfg;
	dp_op_t    op;
	dp_stat_t  stat;
	rsp_item_t rsp_item;
	req_item_t req_item;

	assign req_item = req.data;
	assign rsp.data = rsp_item;

	gdr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stat     (stat),
		.op       (op)
	);

	gdr_dp #(
		.MAP_COLS    (MAP_COLS),
		.MAP_ROWS    (MAP_ROWS),
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg       (cfg),
		.req_item  (req_item),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.rsp_item  (rsp_item),
		.stat      (stat)
	);

endmodule
